// File: rtl/bidr_pkg.sv
package bidr_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] ACT_PACKET     = 2'd0;
    localparam logic [1:0] ACT_CHUNK_SENT = 2'd1;
    localparam logic [1:0] ACT_TX_FAIL    = 2'd2;

    localparam logic [31:0] CMD_HELLO     = 32'h01;
    localparam logic [31:0] CMD_READ      = 32'h03;
    localparam logic [31:0] CMD_END       = 32'h04;
    localparam logic [31:0] CMD_DONE_RESP = 32'h06;
    localparam logic [31:0] CMD_DEV_READY = 32'h0B;

    localparam logic [31:0] LEN_HELLO     = 32'h30;
    localparam logic [31:0] LEN_READ      = 32'h14;
    localparam logic [31:0] PROTO_VERSION = 32'd2;

    localparam logic [26:0] MAX_REQUEST_RST = 27'h6000000;
    localparam logic [15:0] CHUNK_MAX       = 16'hFFFF;

    localparam logic CFG_IMAGE_SIZE  = 1'b0;
    localparam logic CFG_MAX_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        KIND_HELLO,
        KIND_RESET,
        KIND_DONE,
        KIND_SWITCH,
        KIND_DATA
    } t_kind;

    typedef enum logic [2:0] {
        OP_HELLO,
        OP_RESET,
        OP_DONE,
        OP_SWITCH,
        OP_READ,
        OP_NEXT,
        OP_FAIL,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] word;
        logic [31:0] offset;
        logic [26:0] length;
        logic        range_ok;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] echo_mode;
        logic [31:0] chunk_offset;
        logic [15:0] chunk_length;
        logic [31:0] chunk_image;
        logic        final_chunk;
    } t_result;

endpackage

// File: rtl/bidr_in_if.sv
interface bidr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] command_code;
    logic [31:0] packet_length;
    logic [31:0] payload_word0;
    logic [31:0] payload_word1;
    logic [31:0] payload_word2;
    logic [31:0] payload_word3;

    modport source (
        output valid, action, command_code, packet_length,
               payload_word0, payload_word1, payload_word2, payload_word3,
        input  ready
    );

    modport sink (
        input  valid, action, command_code, packet_length,
               payload_word0, payload_word1, payload_word2, payload_word3,
        output ready
    );
endinterface

// File: rtl/bidr_out_if.sv
interface bidr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  send_kind;
    logic [31:0] echo_mode;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_length;
    logic [31:0] chunk_image;
    logic        final_chunk;

    modport source (
        output valid, send_kind, echo_mode, chunk_offset, chunk_length,
               chunk_image, final_chunk,
        input  ready
    );

    modport sink (
        input  valid, send_kind, echo_mode, chunk_offset, chunk_length,
               chunk_image, final_chunk,
        output ready
    );
endinterface

// File: rtl/boot_image_download_responder.sv
// Host side of a chunked boot image download exchange.
// i_in carries one event per transaction: a received packet, a chunk-sent
// completion or a transmit failure. o_out carries the response to transmit
// (hello response, reset, done, switch mode or a data chunk descriptor).
// Events that call for no response produce no o_out transaction.
// The front stage classifies and range-checks each event against the
// image_size / max_request registers (i_cfg_*, index 0 and 1) and pushes a
// command into a 4-entry queue; the back stage owns the transfer state and
// the output register.
// An accepted event passes through the queue, then the output register.
// Throughput: one event per cycle, set by the back stage, absent a stall.
// Reset: config registers return to defaults, transfer state and image
// latch clear, the queue empties and o_out.valid drops.
// Output stall: the output register holds; the back stage stops, the queue
// absorbs up to 4 events, then i_in.ready falls.
module boot_image_download_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    bidr_in_if.sink     i_in,
    bidr_out_if.source  o_out
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    bidr_pkg::t_cmd   q_cmd;
    bidr_pkg::t_qhead q_head;

    bidr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (i_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_cmd)
    );

    bidr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    bidr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .out_ch  (o_out)
    );

    a_data_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.send_kind == bidr_pkg::KIND_DATA)
            |-> (o_out.chunk_length != '0))
        else $error("data chunk with zero length");

    a_final_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.final_chunk)
            |-> (o_out.send_kind == bidr_pkg::KIND_DATA))
        else $error("final flag on non-data response");

    a_echo_only_hello: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.send_kind != bidr_pkg::KIND_HELLO)
            |-> (o_out.echo_mode == '0))
        else $error("echo mode set on non-hello response");

    a_pop_when_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head.valid)
        else $error("pop from empty queue");

endmodule

// File: rtl/bidr_front.sv
module bidr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    bidr_in_if.sink          in_ch,
    input  logic             i_q_full,
    output logic             o_push,
    output bidr_pkg::t_cmd   o_cmd
);

    logic [31:0] r_image_size;
    logic [26:0] r_max_request;
    logic        keep;
    logic [32:0] end_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size  <= '0;
            r_max_request <= bidr_pkg::MAX_REQUEST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bidr_pkg::CFG_IMAGE_SIZE:  r_image_size  <= i_cfg_data;
                bidr_pkg::CFG_MAX_REQUEST: r_max_request <= i_cfg_data[26:0];
                default: ;
            endcase
        end
    end

    assign in_ch.ready = !i_q_full;
    assign end_sum = {1'b0, in_ch.payload_word1} + {1'b0, in_ch.payload_word2};

    always_comb begin
        keep          = 1'b0;
        o_cmd.op      = bidr_pkg::OP_RESET;
        o_cmd.word    = in_ch.payload_word0;
        o_cmd.offset  = in_ch.payload_word1;
        o_cmd.length  = in_ch.payload_word2[26:0];
        o_cmd.range_ok = (in_ch.payload_word2 <= {5'd0, r_max_request})
                      && (in_ch.payload_word1 < r_image_size)
                      && (end_sum <= {1'b0, r_image_size});
        unique case (in_ch.action)
            bidr_pkg::ACT_PACKET: begin
                unique case (in_ch.command_code)
                    bidr_pkg::CMD_HELLO: begin
                        keep       = (in_ch.packet_length == bidr_pkg::LEN_HELLO)
                                  && (in_ch.payload_word0 == bidr_pkg::PROTO_VERSION);
                        o_cmd.op   = bidr_pkg::OP_HELLO;
                        o_cmd.word = in_ch.payload_word3;
                    end
                    bidr_pkg::CMD_READ: begin
                        keep     = 1'b1;
                        o_cmd.op = (in_ch.packet_length == bidr_pkg::LEN_READ)
                                 ? bidr_pkg::OP_READ : bidr_pkg::OP_RESET;
                    end
                    bidr_pkg::CMD_END: begin
                        keep     = (in_ch.payload_word1 == '0);
                        o_cmd.op = bidr_pkg::OP_DONE;
                    end
                    bidr_pkg::CMD_DONE_RESP: begin
                        keep     = 1'b1;
                        o_cmd.op = bidr_pkg::OP_CLEAR;
                    end
                    bidr_pkg::CMD_DEV_READY: begin
                        keep     = 1'b1;
                        o_cmd.op = bidr_pkg::OP_SWITCH;
                    end
                    default: keep = 1'b0;
                endcase
            end
            bidr_pkg::ACT_CHUNK_SENT: begin
                keep     = 1'b1;
                o_cmd.op = bidr_pkg::OP_NEXT;
            end
            bidr_pkg::ACT_TX_FAIL: begin
                keep     = 1'b1;
                o_cmd.op = bidr_pkg::OP_FAIL;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_push = in_ch.valid && in_ch.ready && keep;

endmodule

// File: rtl/bidr_queue.sv
module bidr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bidr_pkg::t_cmd   i_cmd,
    output logic             o_full,
    output bidr_pkg::t_qhead o_head,
    input  logic             i_pop
);

    bidr_pkg::t_cmd          r_mem [bidr_pkg::QDEPTH];
    logic [bidr_pkg::QAW-1:0] r_wp, r_rp;
    logic [bidr_pkg::QAW:0]   r_cnt;

    assign o_full       = (r_cnt == (bidr_pkg::QAW+1)'(bidr_pkg::QDEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/bidr_back.sv
module bidr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bidr_pkg::t_qhead i_head,
    output logic             o_pop,
    bidr_out_if.source       out_ch
);

    logic [31:0] r_offset, n_offset;
    logic [26:0] r_remain, n_remain;
    logic        r_active, n_active;
    logic        r_latched, n_latched;
    logic [31:0] r_image, n_image;
    logic        r_out_valid, n_out_valid;
    bidr_pkg::t_result r_out, n_out;

    logic [31:0] c_off, c_off_next;
    logic [26:0] c_rem, c_rem_next;
    logic        c_act;
    logic [15:0] c_len;
    logic        is_read;

    assign is_read    = (i_head.cmd.op == bidr_pkg::OP_READ);
    assign c_off      = is_read ? i_head.cmd.offset : r_offset;
    assign c_rem      = is_read ? i_head.cmd.length : r_remain;
    assign c_act      = is_read ? 1'b1 : r_active;
    assign c_len      = (c_rem < {11'd0, bidr_pkg::CHUNK_MAX}) ? c_rem[15:0]
                                                               : bidr_pkg::CHUNK_MAX;
    assign c_rem_next = c_rem - {11'd0, c_len};
    assign c_off_next = c_off + {16'd0, c_len};

    assign o_pop = i_head.valid && (!r_out_valid || out_ch.ready);

    always_comb begin
        n_offset    = r_offset;
        n_remain    = r_remain;
        n_active    = r_active;
        n_latched   = r_latched;
        n_image     = r_image;
        n_out_valid = r_out_valid && !out_ch.ready;
        n_out       = r_out;
        if (o_pop) begin
            n_out      = '0;
            n_out.kind = bidr_pkg::KIND_RESET;
            unique case (i_head.cmd.op) inside
                bidr_pkg::OP_HELLO: begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = bidr_pkg::KIND_HELLO;
                    n_out.echo_mode = i_head.cmd.word;
                end
                bidr_pkg::OP_RESET: begin
                    n_out_valid = 1'b1;
                end
                bidr_pkg::OP_DONE: begin
                    n_out_valid = 1'b1;
                    n_out.kind  = bidr_pkg::KIND_DONE;
                end
                bidr_pkg::OP_SWITCH: begin
                    n_out_valid = 1'b1;
                    n_out.kind  = bidr_pkg::KIND_SWITCH;
                end
                bidr_pkg::OP_READ, bidr_pkg::OP_NEXT: begin
                    if (is_read && !r_latched) begin
                        n_latched = 1'b1;
                        n_image   = i_head.cmd.word;
                    end
                    if (is_read && !i_head.cmd.range_ok) begin
                        n_out_valid = 1'b1;
                    end else begin
                        n_offset = c_off;
                        n_remain = c_rem;
                        n_active = c_act;
                        if (c_act && (c_rem != '0)) begin
                            n_offset           = c_off_next;
                            n_remain           = c_rem_next;
                            n_active           = (c_rem_next != '0);
                            n_out_valid        = 1'b1;
                            n_out.kind         = bidr_pkg::KIND_DATA;
                            n_out.chunk_offset = c_off;
                            n_out.chunk_length = c_len;
                            n_out.chunk_image  = n_image;
                            n_out.final_chunk  = (c_rem_next == '0);
                        end
                    end
                end
                bidr_pkg::OP_FAIL: begin
                    n_active = 1'b0;
                end
                bidr_pkg::OP_CLEAR: begin
                    n_active  = 1'b0;
                    n_offset  = '0;
                    n_remain  = '0;
                    n_latched = 1'b0;
                    n_image   = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_remain    <= '0;
            r_active    <= 1'b0;
            r_latched   <= 1'b0;
            r_image     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_offset    <= n_offset;
            r_remain    <= n_remain;
            r_active    <= n_active;
            r_latched   <= n_latched;
            r_image     <= n_image;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign out_ch.valid        = r_out_valid;
    assign out_ch.send_kind    = r_out.kind;
    assign out_ch.echo_mode    = r_out.echo_mode;
    assign out_ch.chunk_offset = r_out.chunk_offset;
    assign out_ch.chunk_length = r_out.chunk_length;
    assign out_ch.chunk_image  = r_out.chunk_image;
    assign out_ch.final_chunk  = r_out.final_chunk;

endmodule

// File: sim/bidr_response_checker.sv
module bidr_response_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    bidr_in_if          i_in,
    bidr_out_if         i_out,
    output int          o_fail_count,
    output int          o_pending
);

    logic [31:0] cfg_image_size;
    logic [26:0] cfg_max_request;

    logic [31:0] run_offset;
    logic [26:0] run_left;
    logic        run_active;
    logic        image_held;
    logic [31:0] session_id;

    bidr_pkg::t_result expected_responses[$];
    int      mismatches = 0;
    int      waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    task automatic clear_session();
        run_active = 1'b0;
        run_offset = '0;
        run_left   = '0;
        image_held = 1'b0;
        session_id = '0;
    endtask

    task automatic push_reply(input bidr_pkg::t_kind kind, input logic [31:0] mode);
        bidr_pkg::t_result r;
        r = '0;
        r.kind = kind;
        r.echo_mode = mode;
        expected_responses.push_back(r);
    endtask

    task automatic issue_chunk();
        bidr_pkg::t_result r;
        logic [15:0]       n;
        if (!run_active || run_left == '0) begin
            return;
        end
        n = (run_left < {11'b0, bidr_pkg::CHUNK_MAX}) ? run_left[15:0]
                                                      : bidr_pkg::CHUNK_MAX;
        r = '0;
        r.kind = bidr_pkg::KIND_DATA;
        r.chunk_offset = run_offset;
        r.chunk_length = n;
        r.chunk_image = session_id;
        run_offset = run_offset + {16'b0, n};
        run_left = run_left - {11'b0, n};
        if (run_left == '0) begin
            run_active = 1'b0;
            r.final_chunk = 1'b1;
        end
        expected_responses.push_back(r);
    endtask

    task automatic predict_response(input logic [1:0] action, input logic [31:0] cmd,
                                    input logic [31:0] plen, input logic [31:0] w0,
                                    input logic [31:0] w1, input logic [31:0] w2,
                                    input logic [31:0] w3);
        logic [32:0] span;
        span = {1'b0, w1} + {1'b0, w2};
        case (action)
            bidr_pkg::ACT_PACKET: begin
                if (cmd == bidr_pkg::CMD_HELLO) begin
                    if (plen == bidr_pkg::LEN_HELLO && w0 == bidr_pkg::PROTO_VERSION)
                        push_reply(bidr_pkg::KIND_HELLO, w3);
                end else if (cmd == bidr_pkg::CMD_READ) begin
                    if (plen != bidr_pkg::LEN_READ) begin
                        push_reply(bidr_pkg::KIND_RESET, '0);
                    end else begin
                        if (!image_held) begin
                            image_held = 1'b1;
                            session_id = w0;
                        end
                        if (w2 > {5'b0, cfg_max_request} || w1 >= cfg_image_size ||
                            span > {1'b0, cfg_image_size}) begin
                            push_reply(bidr_pkg::KIND_RESET, '0);
                        end else begin
                            run_offset = w1;
                            run_left = w2[26:0];
                            run_active = 1'b1;
                            issue_chunk();
                        end
                    end
                end else if (cmd == bidr_pkg::CMD_END) begin
                    if (w1 == '0)
                        push_reply(bidr_pkg::KIND_DONE, '0);
                end else if (cmd == bidr_pkg::CMD_DONE_RESP) begin
                    clear_session();
                end else if (cmd == bidr_pkg::CMD_DEV_READY) begin
                    push_reply(bidr_pkg::KIND_SWITCH, '0);
                end
            end
            bidr_pkg::ACT_CHUNK_SENT: issue_chunk();
            bidr_pkg::ACT_TX_FAIL: run_active = 1'b0;
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    endtask

    task automatic check_response();
        bidr_pkg::t_result want;
        if (expected_responses.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction: expected none, actual kind %0d",
                     $time, i_out.send_kind);
            return;
        end
        want = expected_responses.pop_front();
        if (i_out.send_kind != want.kind)
            note_mismatch("send_kind", 32'(want.kind), 32'(i_out.send_kind));
        if (i_out.echo_mode != want.echo_mode)
            note_mismatch("echo_mode", want.echo_mode, i_out.echo_mode);
        if (i_out.chunk_offset != want.chunk_offset)
            note_mismatch("chunk_offset", want.chunk_offset, i_out.chunk_offset);
        if (i_out.chunk_length != want.chunk_length)
            note_mismatch("chunk_length", 32'(want.chunk_length),
                          32'(i_out.chunk_length));
        if (i_out.chunk_image != want.chunk_image)
            note_mismatch("chunk_image", want.chunk_image, i_out.chunk_image);
        if (i_out.final_chunk != want.final_chunk)
            note_mismatch("final_chunk", 32'(want.final_chunk), 32'(i_out.final_chunk));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_session();
            cfg_image_size = '0;
            cfg_max_request = bidr_pkg::MAX_REQUEST_RST;
            expected_responses.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == bidr_pkg::CFG_IMAGE_SIZE)
                    cfg_image_size = i_cfg_data;
                else
                    cfg_max_request = i_cfg_data[26:0];
            end
            if (i_in.valid && i_in.ready)
                predict_response(i_in.action, i_in.command_code, i_in.packet_length,
                                 i_in.payload_word0, i_in.payload_word1,
                                 i_in.payload_word2, i_in.payload_word3);
            if (i_out.valid && i_out.ready)
                check_response();
        end
        waiting = expected_responses.size();
    end

endmodule

// File: sim/tb.sv
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE = 16;
    localparam int HOLD_CYCLES = 400;
    localparam logic [31:0] CMD_DEVICE_RESET = 32'h07;
    localparam logic [31:0] CMD_UNKNOWN = 32'hFFFF_FFFF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] cmd;
        logic [31:0] plen;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;

    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_req;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          cycles = 0;
    logic [31:0] cur_size;
    logic [26:0] cur_max;

    bidr_in_if  ev_ch();
    bidr_out_if rsp_ch();

    boot_image_download_responder i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (ev_ch),
        .o_out     (rsp_ch)
    );

    bidr_response_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in        (ev_ch),
        .i_out       (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // response side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic t_event packet(input logic [31:0] cmd, input logic [31:0] plen,
                                      input logic [31:0] w0, input logic [31:0] w1,
                                      input logic [31:0] w2, input logic [31:0] w3);
        t_event ev;
        ev.action = bidr_pkg::ACT_PACKET;
        ev.cmd = cmd;
        ev.plen = plen;
        ev.w0 = w0;
        ev.w1 = w1;
        ev.w2 = w2;
        ev.w3 = w3;
        return ev;
    endfunction

    function automatic t_event status_event(input logic [1:0] action);
        t_event ev;
        ev = packet($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        ev.action = action;
        return ev;
    endfunction

    task automatic offer(input t_event ev);
        while ($urandom_range(99) < tx_idle_pct) begin
            ev_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        ev_ch.valid <= 1'b1;
        ev_ch.action <= ev.action;
        ev_ch.command_code <= ev.cmd;
        ev_ch.packet_length <= ev.plen;
        ev_ch.payload_word0 <= ev.w0;
        ev_ch.payload_word1 <= ev.w1;
        ev_ch.payload_word2 <= ev.w2;
        ev_ch.payload_word3 <= ev.w3;
        do @(posedge i_clk); while (!ev_ch.ready);
    endtask

    task automatic drain();
        ev_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] size, input logic [26:0] max_req);
        cfg_we <= 1'b1;
        cfg_idx <= bidr_pkg::CFG_IMAGE_SIZE;
        cfg_data <= size;
        @(posedge i_clk);
        cfg_idx <= bidr_pkg::CFG_MAX_REQUEST;
        cfg_data <= {5'b0, max_req};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_size = size;
        cur_max = max_req;
    endtask

    task automatic random_event(output t_event ev, output bit counts);
        int          r;
        int          sub;
        logic [32:0] room;
        logic [32:0] lim;
        ev = status_event(bidr_pkg::ACT_PACKET);
        counts = 1'b1;
        r = $urandom_range(99);
        sub = $urandom_range(99);
        if (r < 8) begin
            ev.cmd = bidr_pkg::CMD_HELLO;
            if (sub < 85) begin
                ev.plen = bidr_pkg::LEN_HELLO;
                ev.w0 = bidr_pkg::PROTO_VERSION;
            end else if (sub < 92) begin
                ev.plen = bidr_pkg::LEN_HELLO;
            end
        end else if (r < 30) begin
            ev.cmd = bidr_pkg::CMD_READ;
            if (sub < 92)
                ev.plen = bidr_pkg::LEN_READ;
            sub = $urandom_range(99);
            if (sub < 70 && cur_size != '0) begin
                ev.w1 = $urandom % cur_size;
                room = {1'b0, cur_size} - {1'b0, ev.w1};
                if (room > {6'b0, cur_max})
                    room = {6'b0, cur_max};
                lim = (room > 33'd190000) ? 33'd190000 : room;
                if ($urandom_range(19) == 0)
                    ev.w2 = room[31:0];
                else
                    ev.w2 = $urandom_range(lim[31:0], 0);
            end else if (sub < 80) begin
                ev.w1 = (cur_size == '0) ? '0 : $urandom % cur_size;
                ev.w2 = '0;
            end else if (sub < 88) begin
                ev.w2 = {5'b0, cur_max} + 32'd1 + $urandom_range(3);
            end else if (sub < 94) begin
                ev.w1 = cur_size;
                ev.w2 = $urandom_range(3);
            end
        end else if (r < 62) begin
            ev.action = bidr_pkg::ACT_CHUNK_SENT;
        end else if (r < 67) begin
            ev.action = bidr_pkg::ACT_TX_FAIL;
        end else if (r < 74) begin
            ev.cmd = bidr_pkg::CMD_END;
            if (sub < 80)
                ev.w1 = '0;
        end else if (r < 79) begin
            ev.cmd = bidr_pkg::CMD_DONE_RESP;
        end else if (r < 86) begin
            ev.cmd = bidr_pkg::CMD_DEV_READY;
        end else begin
            counts = 1'b0;
            if (sub < 30)
                ev.action = ACT_UNUSED;
            else if (sub < 55)
                ev.cmd = CMD_DEVICE_RESET;
        end
    endtask

    task automatic run_phase(input logic [31:0] size, input logic [26:0] max_req,
                             input int count, input int idle_pct, input logic hold);
        int     done_n;
        t_event ev;
        bit     counts;
        set_config(size, max_req);
        tx_idle_pct = idle_pct;
        rx_idle_pct <= idle_pct;
        hold_req <= hold;
        done_n = 0;
        while (done_n < count) begin
            random_event(ev, counts);
            offer(ev);
            if (counts)
                done_n++;
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = bidr_pkg::CFG_IMAGE_SIZE;
        cfg_data = '0;
        ev_ch.valid = 1'b0;
        ev_ch.action = bidr_pkg::ACT_PACKET;
        ev_ch.command_code = '0;
        ev_ch.packet_length = '0;
        ev_ch.payload_word0 = '0;
        ev_ch.payload_word1 = '0;
        ev_ch.payload_word2 = '0;
        ev_ch.payload_word3 = '0;
        tx_idle_pct = 37;
        rx_idle_pct = 37;
        hold_req = 1'b0;
        cur_size = '0;
        cur_max = bidr_pkg::MAX_REQUEST_RST;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_config(32'hFFFF_FFFF, 27'h7FF_FFFF);
        offer(packet(bidr_pkg::CMD_HELLO, bidr_pkg::LEN_HELLO, bidr_pkg::PROTO_VERSION,
                     32'h0, 32'h0, 32'hFFFF_FFFF));
        offer(packet(bidr_pkg::CMD_HELLO, 32'h31, bidr_pkg::PROTO_VERSION,
                     32'h0, 32'h0, 32'h1234));
        offer(packet(bidr_pkg::CMD_HELLO, bidr_pkg::LEN_HELLO, 32'd1,
                     32'h0, 32'h0, 32'h5678));
        offer(packet(bidr_pkg::CMD_DEV_READY, 32'h8, 32'h0, 32'h0, 32'h0, 32'h0));
        offer(packet(bidr_pkg::CMD_END, 32'h10, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        offer(packet(bidr_pkg::CMD_END, 32'h10, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        // malformed read: reset, no latch
        offer(packet(bidr_pkg::CMD_READ, 32'h0, 32'h1357_9BDF, 32'h0, 32'h4, 32'h0));
        // zero length read latches the image id
        offer(packet(bidr_pkg::CMD_READ, bidr_pkg::LEN_READ, 32'hA5A5_5A5A,
                     32'h0, 32'h0, 32'h0));
        offer(status_event(bidr_pkg::ACT_CHUNK_SENT));
        offer(packet(bidr_pkg::CMD_READ, bidr_pkg::LEN_READ, 32'h1111,
                     32'hFFFF_FFF0, 32'h10, 32'h0));
        offer(packet(bidr_pkg::CMD_READ, bidr_pkg::LEN_READ, 32'h1111,
                     32'hFFFF_FFFE, 32'h1, 32'h0));
        offer(packet(bidr_pkg::CMD_READ, bidr_pkg::LEN_READ, 32'h0,
                     32'h0, 32'h0800_0000, 32'h0));
        offer(packet(bidr_pkg::CMD_READ, bidr_pkg::LEN_READ, 32'h0,
                     32'h1000, 32'h07FF_FFFF, 32'h0));
        offer(status_event(bidr_pkg::ACT_CHUNK_SENT));
        offer(status_event(bidr_pkg::ACT_CHUNK_SENT));
        // new read replaces the running transfer
        offer(packet(bidr_pkg::CMD_READ, bidr_pkg::LEN_READ, 32'h0,
                     32'd100, 32'h1_0000, 32'h0));
        offer(status_event(bidr_pkg::ACT_CHUNK_SENT));
        offer(status_event(bidr_pkg::ACT_CHUNK_SENT));
        offer(packet(bidr_pkg::CMD_DONE_RESP, 32'h8, 32'h0, 32'h0, 32'h0, 32'h0));
        offer(packet(bidr_pkg::CMD_READ, bidr_pkg::LEN_READ, 32'hFFFF_FFFF,
                     32'h0, 32'd200000, 32'h0));
        offer(status_event(bidr_pkg::ACT_TX_FAIL));
        offer(status_event(bidr_pkg::ACT_CHUNK_SENT));
        offer(packet(CMD_DEVICE_RESET, 32'h8, 32'h0, 32'h0, 32'h0, 32'h0));
        offer(packet(CMD_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF));
        offer(status_event(ACT_UNUSED));
        drain();

        run_phase(32'h0, 27'h0, 100, 37, 1'b0);
        run_phase(32'h1, 27'h1, 100, 37, 1'b0);
        run_phase(32'd300000, 27'd70000, 200, 37, 1'b1);
        run_phase(32'hFFFF_FFFF, bidr_pkg::MAX_REQUEST_RST, 200, 0, 1'b1);
        run_phase($urandom, 27'($urandom), 200, 37, 1'b1);
        run_phase($urandom_range(2000000, 1), 27'($urandom_range(2000000, 0)), 200, 37, 1'b1);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
